FILE: hdl/integer_2x2_cramer_solver_unit_defines.svh
// Assertion macros for the 2x2 Cramer solver checker
`ifndef INTEGER_2X2_CRAMER_SOLVER_UNIT_DEFINES_SVH
`define INTEGER_2X2_CRAMER_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset
`define CRS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("crs check failed");

// Next-cycle implication, off during reset
`define CRS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("crs check failed");

// Next-cycle implication that also holds across reset
`define CRS_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("crs check failed");

`endif

FILE: hdl/crs_pkg.sv
// Types and constants of the 2x2 Cramer solver
package crs_pkg;

  localparam int COEF_W  = 16;
  localparam int RHS_W   = 46;
  localparam int DET_W   = 33;            // a*e - b*d
  localparam int NUM_W   = 63;            // c*e - b*f, a*f - c*d
  localparam int DMAG_W  = 32;            // |det| <= 2^31
  localparam int XY_W    = 62;
  localparam int COST_W  = 63;
  localparam int WGT_W   = 4;
  localparam int DIV_STEPS = NUM_W;       // one quotient bit per stage
  localparam int NSTG    = DIV_STEPS + 6; // prod, diff, div in, 63 div, sign, cprod, out
  localparam int S_DIV0  = 2;
  localparam int S_SIGN  = S_DIV0 + DIV_STEPS + 1;
  localparam int S_CPROD = S_SIGN + 1;
  localparam int S_OUT   = S_CPROD + 1;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [2:0] REG_WEIGHT_X = 3'd0;
  localparam logic [2:0] REG_WEIGHT_Y = 3'd4;

  typedef enum logic [2:0] {
    ST_NONNEG     = 3'd0,
    ST_NEGATIVE   = 3'd1,
    ST_FRACTIONAL = 3'd2,
    ST_PARALLEL   = 3'd3,
    ST_COINCIDENT = 3'd4
  } status_t;

  // One step of the shared-divisor restoring divider pair
  typedef struct packed {
    logic [DMAG_W-1:0] rem_x;
    logic [NUM_W-1:0]  nq_x;
    logic [DMAG_W-1:0] rem_y;
    logic [NUM_W-1:0]  nq_y;
    logic [DMAG_W-1:0] dv;
    logic              neg_x;
    logic              neg_y;
    logic              det_zero;
    logic              num_zero;
  } div_t;

endpackage

FILE: hdl/integer_2x2_cramer_solver_unit.sv
// Cramer's rule solver for a 2x2 integer system, top level
// One system is taken per cycle and one result leaves per cycle while out_tready is
// high; a system passes through 69 register stages. At their core is the bit-serial
// restoring divider: 63 pipeline stages, one
// quotient bit each, run the x and y divisions side by side on a shared |det|. Every
// stage holds its item until the next stage frees, so bubbles close up; a stalled output
// blocks the input only once every stage holds an item. Status travels on out_tuser;
// x, y and cost are zero wherever the status says they have no meaning.
module integer_2x2_cramer_solver_unit
  import crs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_a[15:0], coef_b[31:16], rhs_c[77:32], coef_d[93:78], coef_e[109:94],
  // rhs_f[155:110], zero fill
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // x_value[61:0], y_value[123:62], cost[186:124], zero fill
  output logic [191:0] out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [WGT_W-1:0] weight_x_r, weight_y_r;
  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  adv;

  // configuration
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_x_r <= WGT_W'(3);
      weight_y_r <= WGT_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == REG_WEIGHT_X) weight_x_r <= cfg_pwdata[WGT_W-1:0];
      if (cfg_paddr == REG_WEIGHT_Y) weight_y_r <= cfg_pwdata[WGT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr)
      REG_WEIGHT_X: cfg_prdata = {{(32-WGT_W){1'b0}}, weight_x_r};
      REG_WEIGHT_Y: cfg_prdata = {{(32-WGT_W){1'b0}}, weight_y_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // per-stage flow control: a stage loads when it is empty or its item moves on
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int i = NSTG-2; i >= 0; i--) adv[i] = !vld_r[i] || adv[i+1];
  end
  assign in_tready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NSTG; i++) if (adv[i]) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 0: products
  logic signed [COEF_W-1:0] a_in, b_in, d_in, e_in;
  logic signed [RHS_W-1:0]  c_in, f_in;
  assign a_in = in_tdata[15:0];
  assign b_in = in_tdata[31:16];
  assign c_in = in_tdata[77:32];
  assign d_in = in_tdata[93:78];
  assign e_in = in_tdata[109:94];
  assign f_in = in_tdata[155:110];

  logic signed [2*COEF_W-1:0]     pae_r, pbd_r;
  logic signed [RHS_W+COEF_W-1:0] pce_r, pbf_r, paf_r, pcd_r;
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pae_r <= a_in * e_in;
      pbd_r <= b_in * d_in;
      pce_r <= c_in * e_in;
      pbf_r <= b_in * f_in;
      paf_r <= a_in * f_in;
      pcd_r <= c_in * d_in;
    end
  end

  // stage 1: determinant and numerators
  logic signed [DET_W-1:0] det_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      det_r <= DET_W'(pae_r) - DET_W'(pbd_r);
      nx_r  <= NUM_W'(pce_r) - NUM_W'(pbf_r);
      ny_r  <= NUM_W'(paf_r) - NUM_W'(pcd_r);
    end
  end

  // divider stages: div_r[0] holds magnitudes, div_r[k] has k quotient bits done
  div_t div_r [DIV_STEPS+1];
  div_t div_in;
  logic [DET_W-1:0] det_abs;
  always_comb begin
    det_abs         = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    div_in.rem_x    = '0;
    div_in.rem_y    = '0;
    div_in.nq_x     = nx_r[NUM_W-1] ? NUM_W'(-nx_r) : NUM_W'(nx_r);
    div_in.nq_y     = ny_r[NUM_W-1] ? NUM_W'(-ny_r) : NUM_W'(ny_r);
    div_in.dv       = det_abs[DMAG_W-1:0];
    div_in.neg_x    = nx_r[NUM_W-1] ^ det_r[DET_W-1];
    div_in.neg_y    = ny_r[NUM_W-1] ^ det_r[DET_W-1];
    div_in.det_zero = (det_r == '0);
    div_in.num_zero = (nx_r == '0) && (ny_r == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[S_DIV0]) div_r[0] <= div_in;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    div_t             cur, nxt;
    logic [DMAG_W:0]  tx, ty;
    logic             gex, gey;
    always_comb begin
      cur = div_r[k-1];
      tx  = {cur.rem_x, cur.nq_x[NUM_W-1]};
      ty  = {cur.rem_y, cur.nq_y[NUM_W-1]};
      gex = (tx >= {1'b0, cur.dv});
      gey = (ty >= {1'b0, cur.dv});
      nxt = cur;
      nxt.rem_x = gex ? DMAG_W'(tx - {1'b0, cur.dv}) : tx[DMAG_W-1:0];
      nxt.rem_y = gey ? DMAG_W'(ty - {1'b0, cur.dv}) : ty[DMAG_W-1:0];
      nxt.nq_x  = {cur.nq_x[NUM_W-2:0], gex};
      nxt.nq_y  = {cur.nq_y[NUM_W-2:0], gey};
    end
    always_ff @(posedge clk) begin
      if (adv[S_DIV0+k]) div_r[k] <= nxt;
    end
  end

  // sign fix and classification
  div_t                    dq;
  logic [NUM_W-1:0]        qx_s, qy_s;
  logic                    xneg, yneg;
  status_t                 st_nxt;
  logic signed [XY_W-1:0]  x_sign_r, y_sign_r;
  status_t                 st_sign_r;
  always_comb begin
    dq   = div_r[DIV_STEPS];
    qx_s = dq.neg_x ? NUM_W'(-dq.nq_x) : dq.nq_x;
    qy_s = dq.neg_y ? NUM_W'(-dq.nq_y) : dq.nq_y;
    xneg = dq.neg_x && (dq.nq_x != '0);
    yneg = dq.neg_y && (dq.nq_y != '0);
    if (dq.det_zero)                             st_nxt = dq.num_zero ? ST_COINCIDENT : ST_PARALLEL;
    else if (dq.rem_x != '0 || dq.rem_y != '0)   st_nxt = ST_FRACTIONAL;
    else if (xneg || yneg)                       st_nxt = ST_NEGATIVE;
    else                                         st_nxt = ST_NONNEG;
  end

  always_ff @(posedge clk) begin
    if (adv[S_SIGN]) begin
      st_sign_r <= st_nxt;
      x_sign_r  <= (st_nxt == ST_NONNEG || st_nxt == ST_NEGATIVE) ? qx_s[XY_W-1:0] : '0;
      y_sign_r  <= (st_nxt == ST_NONNEG || st_nxt == ST_NEGATIVE) ? qy_s[XY_W-1:0] : '0;
    end
  end

  // weighted terms
  logic [XY_W+WGT_W-1:0]  tx_r, ty_r;
  logic signed [XY_W-1:0] x_cp_r, y_cp_r;
  status_t                st_cp_r;
  always_ff @(posedge clk) begin
    if (adv[S_CPROD]) begin
      st_cp_r <= st_sign_r;
      x_cp_r  <= x_sign_r;
      y_cp_r  <= y_sign_r;
      tx_r    <= (st_sign_r == ST_NONNEG) ?
                 (XY_W+WGT_W)'(weight_x_r) * (XY_W+WGT_W)'(x_sign_r) : '0;
      ty_r    <= (st_sign_r == ST_NONNEG) ?
                 (XY_W+WGT_W)'(weight_y_r) * (XY_W+WGT_W)'(y_sign_r) : '0;
    end
  end

  // saturating sum into the output register
  logic [COST_W-1:0] tx_sat, ty_sat;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cost_nxt;
  always_comb begin
    tx_sat   = (tx_r[XY_W+WGT_W-1:COST_W] != '0) ? COST_MAX : tx_r[COST_W-1:0];
    ty_sat   = (ty_r[XY_W+WGT_W-1:COST_W] != '0) ? COST_MAX : ty_r[COST_W-1:0];
    sum      = {1'b0, tx_sat} + {1'b0, ty_sat};
    cost_nxt = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  end

  logic [XY_W-1:0]   x_out_r, y_out_r;
  logic [COST_W-1:0] cost_out_r;
  status_t           st_out_r;
  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      st_out_r   <= st_cp_r;
      x_out_r    <= x_cp_r;
      y_out_r    <= y_cp_r;
      cost_out_r <= cost_nxt;
    end
  end

  assign out_tvalid = vld_r[S_OUT];
  assign out_tuser  = st_out_r;
  assign out_tdata  = {5'b0, cost_out_r, y_out_r, x_out_r};

endmodule

FILE: hdl/crs_checker.sv
// Port-level checker for the 2x2 Cramer solver, bound to the top level
`include "integer_2x2_cramer_solver_unit_defines.svh"

module crs_checker
  import crs_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [159:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [191:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         cfg_psel,
  input logic         cfg_penable,
  input logic         cfg_pwrite,
  input logic [2:0]   cfg_paddr,
  input logic [31:0]  cfg_pwdata,
  input logic [31:0]  cfg_prdata,
  input logic         cfg_pready
);

  `CRS_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid)

  `CRS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  `CRS_ASSERT_NOW(a_cost_only_nonneg, out_tvalid && out_tuser != ST_NONNEG, out_tdata[186:124] == '0)

  `CRS_ASSERT_NOW(a_xy_zero_no_solution,
    out_tvalid && (out_tuser == ST_FRACTIONAL || out_tuser == ST_PARALLEL ||
    out_tuser == ST_COINCIDENT), out_tdata[123:0] == '0)

endmodule

bind integer_2x2_cramer_solver_unit crs_checker u_crs_checker (.*);
